@@ rtl/bbm_pkg.sv @@
// Package: shared types and constants for bounding box merge clustering.
package bbm_pkg;

  localparam int MaxBoxes = 32;
  localparam int IdxW = $clog2(MaxBoxes);
  localparam int CntW = $clog2(MaxBoxes + 1);
  localparam int CoordW = 12;
  localparam int ExtW = 13;

  localparam logic [0:0] RegDist = 1'b0;
  localparam logic [0:0] RegMilli = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ExtW-1:0] w;
    logic [ExtW-1:0] h;
  } rect_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_COPY,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_PAIR_RD,
    ST_PAIR_EVAL,
    ST_SHIFT,
    ST_PASS_END,
    ST_OUT_RD,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic store_wr;
    logic copy;
    logic sort_load;
    logic sort_shift;
    logic sort_place;
    logic pair_load;
    logic unite;
    logic shift_down;
    logic out_load;
    logic [IdxW-1:0] addr_a;
    logic [IdxW-1:0] addr_b;
    logic by_y;
  } dp_cmd_t;

  typedef struct packed {
    logic key_gt;
    logic match;
  } dp_stat_t;

endpackage

@@ rtl/bbm_datapath.sv @@
// Datapath: box store, work array, sort compare, merge test and output register.
module bbm_datapath
  import bbm_pkg::*;
(
  input  logic clk,
  input  logic [CoordW-1:0] in_x,
  input  logic [CoordW-1:0] in_y,
  input  logic [CoordW-1:0] in_w,
  input  logic [CoordW-1:0] in_h,
  input  logic [CntW-1:0] count,
  input  logic [11:0] dist_thr,
  input  logic [9:0] milli_thr,
  input  dp_cmd_t cmd,
  output dp_stat_t stat,
  output logic [47:0] out_box
);

  logic [47:0] box_store [MaxBoxes];
  rect_t work [MaxBoxes];
  logic [47:0] store_q;
  rect_t ra, rb, tmp;
  logic ev_match;

  always_ff @(posedge clk) begin
    if (cmd.store_wr) box_store[count[IdxW-1:0]] <= {in_h, in_w, in_y, in_x};
    store_q <= box_store[cmd.addr_a];
  end

  function automatic logic [CoordW-1:0] sat12(input logic [ExtW-1:0] v);
    return v[ExtW-1] ? {CoordW{1'b1}} : v[CoordW-1:0];
  endfunction

  function automatic logic [ExtW-1:0] adiff(input logic [ExtW-1:0] a, input logic [ExtW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // near on cross axis and far edges matching on sort axis, or overlapping on both axes
  logic [CoordW-1:0] cp1, cp2, sp1, sp2;
  logic [ExtW-1:0] co1, co2, so1, so2, g1, g2, dend;
  logic [23:0] d1000, lim1, lim2;
  logic near_ok, end_ok, hx, hy;
  always_comb begin
    cp1 = cmd.by_y ? ra.x : ra.y;  co1 = cmd.by_y ? ra.w : ra.h;
    cp2 = cmd.by_y ? rb.x : rb.y;  co2 = cmd.by_y ? rb.w : rb.h;
    sp1 = cmd.by_y ? ra.y : ra.x;  so1 = cmd.by_y ? ra.h : ra.w;
    sp2 = cmd.by_y ? rb.y : rb.x;  so2 = cmd.by_y ? rb.h : rb.w;
    g1 = adiff({1'b0, cp1} + co1, {1'b0, cp2});
    g2 = adiff({1'b0, cp2} + co2, {1'b0, cp1});
    near_ok = (g1 < {1'b0, dist_thr}) || (g2 < {1'b0, dist_thr});
    dend = adiff({1'b0, sp1} + so1, {1'b0, sp2} + so2);
    d1000 = {11'd0, dend} * 24'd1000;
    lim1 = {14'd0, milli_thr} * {11'd0, so1};
    lim2 = {14'd0, milli_thr} * {11'd0, so2};
    end_ok = (d1000 < lim1) || (d1000 < lim2);
    hx = (ra.x < rb.x && ({1'b0, ra.x} + ra.w) > {1'b0, rb.x}) ||
         (rb.x < ra.x && ({1'b0, rb.x} + rb.w) > {1'b0, ra.x});
    hy = (ra.y < rb.y && ({1'b0, ra.y} + ra.h) > {1'b0, rb.y}) ||
         (rb.y < ra.y && ({1'b0, rb.y} + rb.h) > {1'b0, ra.y});
    ev_match = (near_ok && end_ok) || (hx && hy);
  end

  logic [ExtW-1:0] rea, reb, bea, beb;
  rect_t un;
  always_comb begin
    rea = {1'b0, ra.x} + ra.w;  reb = {1'b0, rb.x} + rb.w;
    bea = {1'b0, ra.y} + ra.h;  beb = {1'b0, rb.y} + rb.h;
    un.x = (ra.x <= rb.x) ? ra.x : rb.x;
    un.y = (ra.y <= rb.y) ? ra.y : rb.y;
    un.w = ((rea >= reb) ? rea : reb) - {1'b0, un.x};
    un.h = ((bea >= beb) ? bea : beb) - {1'b0, un.y};
  end

  logic [CoordW-1:0] tkey, pkey;
  always_comb begin
    tkey = cmd.by_y ? tmp.y : tmp.x;
    pkey = cmd.by_y ? rb.y : rb.x;
    stat.key_gt = pkey > tkey;
    stat.match = ev_match;
  end

  always_ff @(posedge clk) begin
    if (cmd.copy) begin
      work[cmd.addr_b] <= '{x: store_q[11:0], y: store_q[23:12],
                            w: {1'b0, store_q[35:24]}, h: {1'b0, store_q[47:36]}};
    end
    if (cmd.sort_load) tmp <= work[cmd.addr_a];
    if (cmd.pair_load || cmd.sort_load) begin
      ra <= work[cmd.addr_a];
      rb <= work[cmd.addr_b];
    end
    if (cmd.sort_shift) begin
      work[cmd.addr_a] <= rb;
      rb <= work[cmd.addr_b];
    end
    if (cmd.sort_place) work[cmd.addr_a] <= tmp;
    if (cmd.unite) work[cmd.addr_a] <= un;
    if (cmd.shift_down) work[cmd.addr_a] <= work[cmd.addr_b];
    if (cmd.out_load) begin
      out_box <= {sat12(work[cmd.addr_a].h), sat12(work[cmd.addr_a].w),
                  work[cmd.addr_a].y, work[cmd.addr_a].x};
    end
  end

endmodule

@@ rtl/bbm_ctrl.sv @@
// Controller: load, sort, pairwise merge and output sequencing.
module bbm_ctrl
  import bbm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic in_lastbit,
  input  logic out_free,
  input  dp_stat_t stat,
  output dp_cmd_t cmd,
  output logic [CntW-1:0] count,
  output logic in_rdy,
  output logic out_set,
  output logic out_lastbit,
  output logic ovf
);

  state_t state, state_next;
  logic [CntW-1:0] n, i, j, k;
  logic [CntW-1:0] n_next, i_next, j_next, k_next;
  logic by_y, changed, round_chg;
  logic by_y_next, changed_next, round_chg_next;
  logic [CntW-1:0] count_next;
  logic ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      ovf <= 1'b0;
      n <= '0; i <= '0; j <= '0; k <= '0;
      by_y <= 1'b0; changed <= 1'b0; round_chg <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf <= ovf_next;
      n <= n_next; i <= i_next; j <= j_next; k <= k_next;
      by_y <= by_y_next; changed <= changed_next; round_chg <= round_chg_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count; ovf_next = ovf;
    n_next = n; i_next = i; j_next = j; k_next = k;
    by_y_next = by_y; changed_next = changed; round_chg_next = round_chg;
    case (state)
      ST_LOAD: begin
        if (in_fire) begin
          if (count < CntW'(MaxBoxes)) count_next = count + 1'b1;
          else ovf_next = 1'b1;
          if (in_lastbit) begin
            n_next = (count < CntW'(MaxBoxes)) ? count + 1'b1 : count;
            i_next = '0;
            k_next = '0;
            state_next = ST_COPY;
          end
        end
      end
      // copy address i trails read address k by the store_q register
      ST_COPY: begin
        if (k != n) k_next = k + 1'b1;
        if (k != '0) i_next = i + 1'b1;
        if ((k != '0 && i + 1'b1 == n) || n == '0) begin
          by_y_next = 1'b0; changed_next = 1'b0; round_chg_next = 1'b0;
          i_next = CntW'(1);
          state_next = ST_SORT_RD;
        end
      end
      ST_SORT_RD: begin
        if (i >= n) begin
          i_next = '0; j_next = CntW'(1);
          state_next = ST_PAIR_RD;
        end else begin
          k_next = i;
          state_next = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        if (k != '0 && stat.key_gt) k_next = k - 1'b1;
        else begin
          i_next = i + 1'b1;
          state_next = ST_SORT_RD;
        end
      end
      ST_PAIR_RD: begin
        if (i >= n) state_next = ST_PASS_END;
        else if (j >= n) begin
          i_next = i + 1'b1; j_next = i + 2'd2;
        end else state_next = ST_PAIR_EVAL;
      end
      ST_PAIR_EVAL: begin
        if (stat.match) begin
          changed_next = 1'b1;
          k_next = j;
          state_next = ST_SHIFT;
        end else begin
          j_next = j + 1'b1;
          state_next = ST_PAIR_RD;
        end
      end
      ST_SHIFT: begin
        if (k + 1'b1 >= n) begin
          n_next = n - 1'b1;
          j_next = i + 1'b1;
          state_next = ST_PAIR_RD;
        end else k_next = k + 1'b1;
      end
      ST_PASS_END: begin
        i_next = CntW'(1);
        if (!by_y) begin
          by_y_next = 1'b1;
          round_chg_next = changed;
          changed_next = 1'b0;
          state_next = ST_SORT_RD;
        end else if (changed || round_chg) begin
          by_y_next = 1'b0;
          changed_next = 1'b0;
          state_next = ST_SORT_RD;
        end else begin
          i_next = '0;
          state_next = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        if (i >= n) begin
          count_next = '0; ovf_next = 1'b0;
          state_next = ST_LOAD;
        end else if (out_free) state_next = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        i_next = i + 1'b1;
        state_next = ST_OUT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.by_y = by_y;
    in_rdy = 1'b0;
    out_set = 1'b0;
    out_lastbit = 1'b0;
    case (state)
      ST_LOAD: begin
        in_rdy = 1'b1;
        cmd.store_wr = in_fire && (count < CntW'(MaxBoxes));
      end
      ST_COPY: begin
        cmd.addr_a = k[IdxW-1:0];
        cmd.addr_b = i[IdxW-1:0];
        cmd.copy = (k != '0);
      end
      ST_SORT_RD: begin
        cmd.addr_a = i[IdxW-1:0];
        cmd.addr_b = IdxW'(i - 1'b1);
        cmd.sort_load = (i < n);
      end
      ST_SORT_CMP: begin
        // rb holds work[k-1]; shift it up or drop tmp at k
        cmd.addr_a = k[IdxW-1:0];
        cmd.addr_b = IdxW'(k - 2'd2);
        if (k != '0 && stat.key_gt) cmd.sort_shift = 1'b1;
        else cmd.sort_place = 1'b1;
      end
      ST_PAIR_RD: begin
        cmd.addr_a = i[IdxW-1:0];
        cmd.addr_b = j[IdxW-1:0];
        cmd.pair_load = 1'b1;
      end
      ST_PAIR_EVAL: begin
        cmd.addr_a = i[IdxW-1:0];
        cmd.unite = stat.match;
      end
      ST_SHIFT: begin
        cmd.addr_a = k[IdxW-1:0];
        cmd.addr_b = IdxW'(k + 1'b1);
        cmd.shift_down = (k + 1'b1 < n);
      end
      ST_OUT_RD: begin
        cmd.addr_a = i[IdxW-1:0];
        cmd.out_load = (i < n) && out_free;
        out_set = (i < n) && out_free;
        out_lastbit = (i + 1'b1 == n);
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/bounding_box_merge_clustering.sv @@
// Top level: bounding box merge clustering with stream ports.
// Loading accepts one box per cycle. After the last box: a copy into the work array, then rounds of an
// insertion sort and a pairwise merge scan per axis, repeated until a round makes no merge;
// the work array sets the pace. Each result passes through ST_OUT_RD and ST_OUT_WAIT, waiting
// for a free output. rst clears the count and overflow flag and sets thresholds to 50 and 300.
module bounding_box_merge_clustering
  import bbm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [47:0] s_tdata,  // box_x, box_y, box_width, box_height
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [47:0] m_tdata,  // out_x, out_y, out_width, out_height
  output logic m_tlast,
  output logic m_tuser,         // overflow
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [11:0] cfg_data
);

  logic [11:0] dist_thr;
  logic [9:0] milli_thr;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [CntW-1:0] count;
  logic in_rdy, out_set, out_lastbit, ovf;
  logic [47:0] out_box;
  logic pend, pend_last, in_fire, out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_thr <= 12'd50;
      milli_thr <= 10'd300;
    end else if (cfg_we) begin
      case (cfg_index)
        RegDist: dist_thr <= cfg_data;
        RegMilli: milli_thr <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign s_tready = in_rdy;
  assign in_fire = s_tvalid && in_rdy;
  assign out_free = !m_tvalid || m_tready;

  bbm_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_lastbit(s_tlast), .out_free, .stat, .cmd, .count,
    .in_rdy, .out_set, .out_lastbit, .ovf
  );

  bbm_datapath u_dp (
    .clk, .in_x(s_tdata[11:0]), .in_y(s_tdata[23:12]), .in_w(s_tdata[35:24]),
    .in_h(s_tdata[47:36]), .count, .dist_thr, .milli_thr, .cmd, .stat, .out_box
  );

  // out_box lands in the cycle after out_set, alongside pend
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      pend <= out_set;
      if (pend) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_set) begin
      pend_last <= out_lastbit;
      m_tuser <= ovf;
    end
    if (pend) begin
      m_tdata <= out_box;
      m_tlast <= pend_last;
    end
  end

endmodule
